// File: design/sqd_pkg.sv
// sqd_pkg: sizes, register codes and the result record of the
// join-shortest-queue dispatcher. No dependencies.
`timescale 1ns / 1ps

package sqd_pkg;

   // Bank geometry
   localparam int NUM_SERVERS = 4;
   localparam int QUEUE_DEPTH = 16;

   // Derived widths
   localparam int SRV_IDX_W  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
   localparam int SRV_CNT_W  = $clog2(NUM_SERVERS + 1);
   localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int LEN_W      = $clog2(NUM_SERVERS * QUEUE_DEPTH + 1);
   localparam int TICK_W     = 32;
   localparam int TIME_W     = 4;
   localparam int CNT_W      = 32;
   localparam int SUM_W      = 48;
   localparam int WAIT_ADD_W = TICK_W + SRV_CNT_W;

   // Field widths of the ports
   localparam int LIMIT_W    = 5;
   localparam int SERVERS_W  = 3;
   localparam int CHOSEN_W   = 2;
   localparam int SERVED_W   = 3;
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;

   // Reset values of the configuration registers
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = LIMIT_W'(16);
   localparam logic [SERVERS_W-1:0] SERVERS_RESET = SERVERS_W'(4);

   // Register index, taken from the word address
   typedef enum logic [0:0] {
      REG_QUEUE_LIMIT    = 1'b0,
      REG_SERVERS_IN_USE = 1'b1
   } csr_reg_type;

   // One result item
   typedef struct packed {
      logic                accepted;
      logic                turned_away;
      logic [CHOSEN_W-1:0] chosen_server;
      logic [SERVED_W-1:0] served_now;
      logic [CNT_W-1:0]    accepted_count;
      logic [CNT_W-1:0]    rejected_count;
      logic [CNT_W-1:0]    served_count;
      logic [SUM_W-1:0]    queue_length_total;
      logic [SUM_W-1:0]    wait_total;
   } rsp_type;

endpackage

// File: design/shortest_queue_dispatch_servers.sv
// shortest_queue_dispatch_servers: join-shortest-queue dispatch over a bank of
// servers, one simulated tick per input item. Depends on sqd_pkg.
//
//   channel  ports   direction  handshake          payload
//   req      req_*   in         req_valid/ready    arrival, service_time
//   rsp      rsp_*   out        rsp_valid/ready    counts and totals
//   csr      csr_*   in/out     APB, pready high   queue_limit, servers_in_use
//
// One item per cycle sustained while rsp_ready is high: an item is held in
// the input register, then the whole tick (queue pick, per-server dequeue,
// timer step, saturating sums) is one pass of logic into the result register.
// Reset is synchronous, clears queue pointers, timers and totals, and loads
// the reset configuration; the entry store holds no reset. A stalled result
// holds the result register; the input register then fills and drops req_ready.
`timescale 1ns / 1ps

module shortest_queue_dispatch_servers (
   input  logic                          clock,
   input  logic                          reset,
   // input items
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_arrival,
   input  logic [sqd_pkg::TIME_W-1:0]    req_service_time,
   // result items
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic                          rsp_turned_away,
   output logic [sqd_pkg::CHOSEN_W-1:0]  rsp_chosen_server,
   output logic [sqd_pkg::SERVED_W-1:0]  rsp_served_now,
   output logic [sqd_pkg::CNT_W-1:0]     rsp_accepted_count,
   output logic [sqd_pkg::CNT_W-1:0]     rsp_rejected_count,
   output logic [sqd_pkg::CNT_W-1:0]     rsp_served_count,
   output logic [sqd_pkg::SUM_W-1:0]     rsp_queue_length_total,
   output logic [sqd_pkg::SUM_W-1:0]     rsp_wait_total,
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sqd_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [sqd_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [sqd_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready
);

   localparam int NS = sqd_pkg::NUM_SERVERS;
   localparam int QD = sqd_pkg::QUEUE_DEPTH;

   // configuration registers
   logic [sqd_pkg::LIMIT_W-1:0]   queue_limit_ff;
   logic [sqd_pkg::SERVERS_W-1:0] servers_ff;
   logic                          csr_write;
   sqd_pkg::csr_reg_type          csr_reg;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic                          in_arrival_ff;
   logic [sqd_pkg::TIME_W-1:0]    in_time_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   sqd_pkg::rsp_type              rsp_ff, rsp_in;

   // queue state
   logic [sqd_pkg::TICK_W-1:0]    entry_tick_ff [NS][QD];
   logic [sqd_pkg::TIME_W-1:0]    entry_time_ff [NS][QD];
   logic [NS-1:0][sqd_pkg::PTR_W-1:0]  head_ff, head_in, wr_ptr;
   logic [NS-1:0][sqd_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [NS-1:0][sqd_pkg::TIME_W-1:0] timer_ff, timer_in;
   logic [sqd_pkg::TICK_W-1:0]    tick_ff;
   logic [sqd_pkg::CNT_W-1:0]     acc_total_ff, rej_total_ff, srv_total_ff;
   logic [sqd_pkg::SUM_W-1:0]     len_sum_ff, wait_sum_ff;

   // tick logic
   logic                          advance;
   logic [sqd_pkg::FILL_W-1:0]    limit_eff;
   logic [sqd_pkg::SRV_CNT_W-1:0] nsrv_eff;
   logic [NS-1:0]                 active;
   logic                          found, enq, rej;
   logic [sqd_pkg::SRV_IDX_W-1:0] chosen;
   logic [sqd_pkg::FILL_W-1:0]    best_fill;
   logic [sqd_pkg::SRV_CNT_W-1:0] served_now;
   logic [sqd_pkg::LEN_W-1:0]     lens;
   logic [sqd_pkg::WAIT_ADD_W-1:0] wait_add;
   logic [sqd_pkg::CNT_W:0]       srv_sum;
   logic [sqd_pkg::SUM_W:0]       len_sum, wait_sum;
   logic [sqd_pkg::CNT_W-1:0]     acc_total_in, rej_total_in, srv_total_in;
   logic [sqd_pkg::SUM_W-1:0]     len_sum_in, wait_sum_in;

   // handshakes
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_reg    = sqd_pkg::csr_reg_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_reg)
         sqd_pkg::REG_QUEUE_LIMIT:
            csr_prdata = sqd_pkg::DATA_W'(queue_limit_ff);
         sqd_pkg::REG_SERVERS_IN_USE:
            csr_prdata = sqd_pkg::DATA_W'(servers_ff);
      endcase
   end

   // clamp the configuration into range
   always_comb begin
      if (queue_limit_ff == '0) begin
         limit_eff = sqd_pkg::FILL_W'(1);
      end else if (int'(queue_limit_ff) > QD) begin
         limit_eff = sqd_pkg::FILL_W'(QD);
      end else begin
         limit_eff = sqd_pkg::FILL_W'(queue_limit_ff);
      end
      if (servers_ff == '0) begin
         nsrv_eff = sqd_pkg::SRV_CNT_W'(1);
      end else if (int'(servers_ff) > NS) begin
         nsrv_eff = sqd_pkg::SRV_CNT_W'(NS);
      end else begin
         nsrv_eff = sqd_pkg::SRV_CNT_W'(servers_ff);
      end
      for (int i = 0; i < NS; i++) begin
         active[i] = (i < int'(nsrv_eff));
      end
   end

   // pick the shortest non-full active queue, lowest index on a tie
   always_comb begin
      found     = 1'b0;
      chosen    = '0;
      best_fill = '0;
      for (int i = 0; i < NS; i++) begin
         if (active[i] && fill_ff[i] < limit_eff && (!found || fill_ff[i] < best_fill)) begin
            found     = 1'b1;
            chosen    = sqd_pkg::SRV_IDX_W'(i);
            best_fill = fill_ff[i];
         end
      end
      enq = in_arrival_ff && found;
      rej = in_arrival_ff && !found;
   end

   // per-server dequeue, timer step and length/wait sums
   always_comb begin
      logic [sqd_pkg::FILL_W:0]    slot;
      logic [sqd_pkg::FILL_W-1:0]  fill_mid;
      logic                        here, deq;
      logic [sqd_pkg::TICK_W-1:0]  head_tick, head_wait;
      logic [sqd_pkg::TIME_W-1:0]  head_time, timer_mid;
      served_now = '0;
      lens       = '0;
      wait_add   = '0;
      for (int i = 0; i < NS; i++) begin
         // write slot: (head + fill) wrapped at the ring depth
         slot = (sqd_pkg::FILL_W+1)'(head_ff[i]) + (sqd_pkg::FILL_W+1)'(fill_ff[i]);
         if (int'(slot) >= QD) begin
            slot = slot - (sqd_pkg::FILL_W+1)'(QD);
         end
         wr_ptr[i] = sqd_pkg::PTR_W'(slot);
         here      = enq && (chosen == sqd_pkg::SRV_IDX_W'(i));
         fill_mid  = fill_ff[i] + sqd_pkg::FILL_W'(here);
         deq       = active[i] && timer_ff[i] == '0 && fill_mid != '0;
         // an empty queue that just took the arrival serves it directly when its timer is zero
         if (fill_ff[i] == '0) begin
            head_tick = tick_ff;
            head_time = in_time_ff;
         end else begin
            head_tick = entry_tick_ff[i][head_ff[i]];
            head_time = entry_time_ff[i][head_ff[i]];
         end
         // wait wraps at the tick counter width
         head_wait = tick_ff - head_tick;
         timer_mid = deq ? head_time : timer_ff[i];
         if (active[i] && timer_mid != '0) begin
            timer_in[i] = timer_mid - 1'b1;
         end else begin
            timer_in[i] = timer_mid;
         end
         if (deq) begin
            head_in[i] = (int'(head_ff[i]) == QD - 1) ? '0 : head_ff[i] + 1'b1;
         end else begin
            head_in[i] = head_ff[i];
         end
         fill_in[i] = fill_mid - sqd_pkg::FILL_W'(deq);
         served_now = served_now + sqd_pkg::SRV_CNT_W'(deq);
         if (deq) begin
            wait_add = wait_add + sqd_pkg::WAIT_ADD_W'(head_wait);
         end
         if (active[i]) begin
            lens = lens + sqd_pkg::LEN_W'(fill_in[i]);
         end
      end
   end

   // saturating totals
   always_comb begin
      acc_total_in = acc_total_ff;
      if (enq && acc_total_ff != '1) begin
         acc_total_in = acc_total_ff + 1'b1;
      end
      rej_total_in = rej_total_ff;
      if (rej && rej_total_ff != '1) begin
         rej_total_in = rej_total_ff + 1'b1;
      end
      srv_sum      = (sqd_pkg::CNT_W+1)'(srv_total_ff) + (sqd_pkg::CNT_W+1)'(served_now);
      srv_total_in = srv_sum[sqd_pkg::CNT_W] ? '1 : srv_sum[sqd_pkg::CNT_W-1:0];
      len_sum      = (sqd_pkg::SUM_W+1)'(len_sum_ff) + (sqd_pkg::SUM_W+1)'(lens);
      len_sum_in   = len_sum[sqd_pkg::SUM_W] ? '1 : len_sum[sqd_pkg::SUM_W-1:0];
      wait_sum     = (sqd_pkg::SUM_W+1)'(wait_sum_ff) + (sqd_pkg::SUM_W+1)'(wait_add);
      wait_sum_in  = wait_sum[sqd_pkg::SUM_W] ? '1 : wait_sum[sqd_pkg::SUM_W-1:0];
   end

   // result item
   always_comb begin
      rsp_in.accepted           = enq;
      rsp_in.turned_away        = rej;
      rsp_in.chosen_server      = enq ? sqd_pkg::CHOSEN_W'(chosen) : '0;
      rsp_in.served_now         = sqd_pkg::SERVED_W'(served_now);
      rsp_in.accepted_count     = acc_total_in;
      rsp_in.rejected_count     = rej_total_in;
      rsp_in.served_count       = srv_total_in;
      rsp_in.queue_length_total = len_sum_in;
      rsp_in.wait_total         = wait_sum_in;
   end

   assign rsp_accepted           = rsp_ff.accepted;
   assign rsp_turned_away        = rsp_ff.turned_away;
   assign rsp_chosen_server      = rsp_ff.chosen_server;
   assign rsp_served_now         = rsp_ff.served_now;
   assign rsp_accepted_count     = rsp_ff.accepted_count;
   assign rsp_rejected_count     = rsp_ff.rejected_count;
   assign rsp_served_count       = rsp_ff.served_count;
   assign rsp_queue_length_total = rsp_ff.queue_length_total;
   assign rsp_wait_total         = rsp_ff.wait_total;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         queue_limit_ff <= sqd_pkg::LIMIT_RESET;
         servers_ff     <= sqd_pkg::SERVERS_RESET;
         head_ff        <= '0;
         fill_ff        <= '0;
         timer_ff       <= '0;
         tick_ff        <= '0;
         acc_total_ff   <= '0;
         rej_total_ff   <= '0;
         srv_total_ff   <= '0;
         len_sum_ff     <= '0;
         wait_sum_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_reg)
               sqd_pkg::REG_QUEUE_LIMIT:
                  queue_limit_ff <= csr_pwdata[sqd_pkg::LIMIT_W-1:0];
               sqd_pkg::REG_SERVERS_IN_USE:
                  servers_ff <= csr_pwdata[sqd_pkg::SERVERS_W-1:0];
            endcase
         end
         if (advance) begin
            head_ff      <= head_in;
            fill_ff      <= fill_in;
            timer_ff     <= timer_in;
            tick_ff      <= tick_ff + 1'b1;
            acc_total_ff <= acc_total_in;
            rej_total_ff <= rej_total_in;
            srv_total_ff <= srv_total_in;
            len_sum_ff   <= len_sum_in;
            wait_sum_ff  <= wait_sum_in;
         end
      end
   end

   // payload registers and entry store
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_arrival_ff <= req_arrival;
         in_time_ff    <= req_service_time;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
      if (advance && enq) begin
         entry_tick_ff[chosen][wr_ptr[chosen]] <= tick_ff;
         entry_time_ff[chosen][wr_ptr[chosen]] <= in_time_ff;
      end
   end

   // checks
   logic fill_ok;
   always_comb begin
      fill_ok = 1'b1;
      for (int i = 0; i < NS; i++) begin
         if (int'(fill_ff[i]) > QD) begin
            fill_ok = 1'b0;
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset) fill_ok)
      else $error("queue fill above ring depth");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> tick_ff == $past(tick_ff) + 1'b1)
      else $error("tick counter did not step with a processed item");

   a_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.accepted && rsp_ff.turned_away)
                       && (rsp_ff.accepted || rsp_ff.chosen_server == '0))
      else $error("inconsistent arrival outcome in result");

endmodule
